// ----- hdl/dlf_pkg.sv -----
// Shared types and constants for the display link framer.
package dlf_pkg;

    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] DC1_BYTE   = 8'h11;
    localparam logic [7:0] DC2_BYTE   = 8'h12;
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] RD_ONE     = 8'h01;
    localparam logic [7:0] RD_S       = 8'h53;
    localparam logic [7:0] RD_SUM     = 8'h66;
    localparam int         MAX_RES    = 4;

    typedef enum logic [1:0] {
        CMD_WRITE_BEGIN  = 2'd0,
        CMD_WRITE_BYTE   = 2'd1,
        CMD_READ_REQUEST = 2'd2,
        CMD_RX_BYTE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_WSTATUS = 2'd1,
        KIND_RLEN    = 2'd2,
        KIND_RDATA   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WPAY  = 3'd1,
        PH_WACK  = 3'd2,
        PH_RACK  = 3'd3,
        PH_RSKIP = 3'd4,
        PH_RLEN  = 3'd5,
        PH_RDATA = 3'd6,
        PH_RCSUM = 3'd7
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       status;
        logic       last;
    } result_t;

endpackage

// ----- hdl/display_link_framer_top.sv -----
// Display link framer: command framing and reply deframing, top level.
//
// Input channel s_*: one transaction per host command or received byte.
//   tuser carries the command, tdata the byte, frame length and buffer ready flag.
// Output channel m_*: one transaction per result (transmit byte, write status,
//   read length or read data byte); tlast marks the end of each run.
// Latency: the first result of an accepted item is on m_* in the next cycle.
// Throughput: one item per cycle while each item yields at most one result and
//   m_tready stays high; an item with several results holds the result queue
//   until all have left the single-result-per-cycle output port. A new item is
//   taken in the same cycle as the final result of the previous one leaves.
// Items that yield no result only update the phase state and byte counter.
// Reset clears the phase, counters and result queue; m_tvalid drops at once.
// When the receiver stalls, the queued result holds and s_tready stays low
// until the last queued result is taken.
module display_link_framer_top
    import dlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [15:8] frame_length, [16] buffer_ready
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [8] status
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] sum_reg, sum_next;

    result_t    res_reg [MAX_RES];
    result_t    res_next [MAX_RES];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg;
    logic [2:0] nres;

    cmd_t       cmd;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       buffer_ready;
    logic       accept;
    logic       pop;
    logic       pop_final;
    logic [7:0] hdr;
    logic [7:0] hdr_sum;
    logic [7:0] rem_dec;
    logic [7:0] sum_add;

    assign cmd          = cmd_t'(s_tuser);
    assign data_byte    = s_tdata[7:0];
    assign frame_length = s_tdata[15:8];
    assign buffer_ready = s_tdata[16];

    assign m_tvalid  = (cnt_reg != 3'd0);
    assign pop       = m_tvalid && m_tready;
    assign pop_final = pop && (({1'b0, rd_reg} + 3'd1) == cnt_reg);
    assign s_tready  = (cnt_reg == 3'd0) || pop_final;
    assign accept    = s_tvalid && s_tready;

    assign m_tdata = {7'd0, res_reg[rd_reg].status, res_reg[rd_reg].value};
    assign m_tuser = res_reg[rd_reg].kind;
    assign m_tlast = res_reg[rd_reg].last;

    assign hdr     = frame_length + 8'd1;
    assign hdr_sum = DC1_BYTE + hdr + ESC_BYTE;
    assign rem_dec = remaining_reg - 8'd1;
    assign sum_add = sum_reg + data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        nres           = 3'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '{kind: KIND_TX, value: 8'd0, status: 1'b0, last: 1'b0};
        end
        case (cmd)
            CMD_WRITE_BEGIN:
            begin
                sum_next          = hdr_sum;
                res_next[0].value = DC1_BYTE;
                res_next[1].value = hdr;
                res_next[2].value = ESC_BYTE;
                if (frame_length == 8'd0)
                begin
                    res_next[3].value = hdr_sum;
                    res_next[3].last  = 1'b1;
                    nres              = 3'd4;
                    remaining_next    = 8'd0;
                    phase_next        = PH_WACK;
                end
                else
                begin
                    res_next[2].last = 1'b1;
                    nres             = 3'd3;
                    remaining_next   = frame_length;
                    phase_next       = PH_WPAY;
                end
            end
            CMD_WRITE_BYTE:
            begin
                if (phase_reg != PH_WPAY || remaining_reg == 8'd0)
                begin
                    phase_next     = PH_IDLE;
                    remaining_next = 8'd0;
                end
                else
                begin
                    remaining_next    = rem_dec;
                    sum_next          = sum_add;
                    res_next[0].value = data_byte;
                    if (rem_dec == 8'd0)
                    begin
                        res_next[1].value = sum_add;
                        res_next[1].last  = 1'b1;
                        nres              = 3'd2;
                        phase_next        = PH_WACK;
                    end
                    else
                    begin
                        res_next[0].last = 1'b1;
                        nres             = 3'd1;
                    end
                end
            end
            CMD_READ_REQUEST:
            begin
                remaining_next = 8'd0;
                if (!buffer_ready)
                begin
                    phase_next       = PH_IDLE;
                    res_next[0].kind = KIND_RLEN;
                    res_next[0].last = 1'b1;
                    nres             = 3'd1;
                end
                else
                begin
                    sum_next          = RD_SUM;
                    res_next[0].value = DC2_BYTE;
                    res_next[1].value = RD_ONE;
                    res_next[2].value = RD_S;
                    res_next[3].value = RD_SUM;
                    res_next[3].last  = 1'b1;
                    nres              = 3'd4;
                    phase_next        = PH_RACK;
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_WACK:
                    begin
                        res_next[0].kind   = KIND_WSTATUS;
                        res_next[0].status = (data_byte != ACK_BYTE);
                        res_next[0].last   = 1'b1;
                        nres               = 3'd1;
                        phase_next         = PH_IDLE;
                    end
                    PH_RACK:
                    begin
                        if (data_byte != ACK_BYTE)
                        begin
                            res_next[0].kind = KIND_RLEN;
                            res_next[0].last = 1'b1;
                            nres             = 3'd1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_RSKIP;
                        end
                    end
                    PH_RSKIP:
                    begin
                        phase_next = PH_RLEN;
                    end
                    PH_RLEN:
                    begin
                        remaining_next    = data_byte;
                        res_next[0].kind  = KIND_RLEN;
                        res_next[0].value = data_byte;
                        res_next[0].last  = (data_byte == 8'd0);
                        nres              = 3'd1;
                        phase_next        = (data_byte == 8'd0) ? PH_RCSUM : PH_RDATA;
                    end
                    PH_RDATA:
                    begin
                        res_next[0].kind  = KIND_RDATA;
                        res_next[0].value = data_byte;
                        nres              = 3'd1;
                        if (remaining_reg == 8'd0 || rem_dec == 8'd0)
                        begin
                            remaining_next   = 8'd0;
                            res_next[0].last = 1'b1;
                            phase_next       = PH_RCSUM;
                        end
                        else
                        begin
                            remaining_next = rem_dec;
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        remaining_next = 8'd0;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = nres;
        end
        else if (pop_final)
        begin
            cnt_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
            cnt_reg       <= 3'd0;
            rd_reg        <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                sum_reg       <= sum_next;
                rd_reg        <= 2'd0;
            end
            else if (pop_final)
            begin
                rd_reg <= 2'd0;
            end
            else if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

// ----- hdl/dlf_checker.sv -----
// Port-level checker for the display link framer, bound to the top level.
module dlf_checker
    import dlf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result queue");

    a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_READ_REQUEST && !s_tdata[16]
        |=> m_tvalid && m_tuser == KIND_RLEN && m_tlast && m_tdata[7:0] == 8'd0)
        else $error("buffer-not-ready read did not report length zero");

    a_write_header: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_WRITE_BEGIN
        |=> m_tvalid && m_tuser == KIND_TX && m_tdata[7:0] == DC1_BYTE && !m_tlast)
        else $error("write frame did not open with DC1");

endmodule

bind display_link_framer_top dlf_checker u_dlf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- test/link_frame_checker.sv -----
// Checker for the display link framer: predicts results per accepted command and compares them.
`timescale 1ns / 1ps
module link_frame_checker
    import dlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [15:8] frame_length, [16] buffer_ready
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] value, [8] status
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,
    output int          fail_total,
    output int          open_results,
    output int          results_seen
);

    phase_t     link_phase;
    logic [7:0] bytes_left;
    logic [7:0] frame_sum;
    result_t    expected_results[$];
    int         fails;
    int         seen;

    task automatic queue_result(input kind_t kind, input logic [7:0] value,
                                input logic status, input logic last);
        result_t r;
        r.kind   = kind;
        r.value  = value;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // every byte sent through this task counts toward the frame checksum
    task automatic queue_tx_byte(input logic [7:0] b, input logic last);
        frame_sum = frame_sum + b;
        queue_result(KIND_TX, b, 1'b0, last);
    endtask

    task automatic frame_link_item(input cmd_t cmd, input logic [7:0] rx,
                                   input logic [7:0] flen, input logic rdy);
        case (cmd)
            CMD_WRITE_BEGIN:
            begin
                frame_sum = 8'h00;
                queue_tx_byte(DC1_BYTE, 1'b0);
                queue_tx_byte(flen + 8'd1, 1'b0);
                if (flen == 8'd0)
                begin
                    queue_tx_byte(ESC_BYTE, 1'b0);
                    queue_result(KIND_TX, frame_sum, 1'b0, 1'b1);
                    bytes_left = 8'd0;
                    link_phase = PH_WACK;
                end
                else
                begin
                    queue_tx_byte(ESC_BYTE, 1'b1);
                    bytes_left = flen;
                    link_phase = PH_WPAY;
                end
            end
            CMD_WRITE_BYTE:
            begin
                if (link_phase != PH_WPAY || bytes_left == 8'd0)
                begin
                    link_phase = PH_IDLE;
                    bytes_left = 8'd0;
                end
                else
                begin
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                    begin
                        queue_tx_byte(rx, 1'b0);
                        queue_result(KIND_TX, frame_sum, 1'b0, 1'b1);
                        link_phase = PH_WACK;
                    end
                    else
                        queue_tx_byte(rx, 1'b1);
                end
            end
            CMD_READ_REQUEST:
            begin
                bytes_left = 8'd0;
                if (!rdy)
                begin
                    link_phase = PH_IDLE;
                    queue_result(KIND_RLEN, 8'h00, 1'b0, 1'b1);
                end
                else
                begin
                    frame_sum = 8'h00;
                    queue_tx_byte(DC2_BYTE, 1'b0);
                    queue_tx_byte(RD_ONE, 1'b0);
                    queue_tx_byte(RD_S, 1'b0);
                    queue_result(KIND_TX, frame_sum, 1'b0, 1'b1);
                    link_phase = PH_RACK;
                end
            end
            default:
            begin
                case (link_phase)
                    PH_WACK:
                    begin
                        queue_result(KIND_WSTATUS, 8'h00, rx != ACK_BYTE, 1'b1);
                        link_phase = PH_IDLE;
                    end
                    PH_RACK:
                    begin
                        if (rx != ACK_BYTE)
                        begin
                            queue_result(KIND_RLEN, 8'h00, 1'b0, 1'b1);
                            link_phase = PH_IDLE;
                        end
                        else
                            link_phase = PH_RSKIP;
                    end
                    PH_RSKIP:
                        link_phase = PH_RLEN;
                    PH_RLEN:
                    begin
                        bytes_left = rx;
                        queue_result(KIND_RLEN, rx, 1'b0, rx == 8'd0);
                        link_phase = (rx == 8'd0) ? PH_RCSUM : PH_RDATA;
                    end
                    PH_RDATA:
                    begin
                        if (bytes_left != 8'd0)
                            bytes_left = bytes_left - 8'd1;
                        queue_result(KIND_RDATA, rx, 1'b0, bytes_left == 8'd0);
                        if (bytes_left == 8'd0)
                            link_phase = PH_RCSUM;
                    end
                    default:
                    begin
                        // trailing checksum dropped, or a stray byte
                        link_phase = PH_IDLE;
                        bytes_left = 8'd0;
                    end
                endcase
            end
        endcase
    endtask

    task automatic compare_result(input logic [1:0] kind, input logic [7:0] value,
                                  input logic status, input logic last);
        result_t want;
        seen++;
        if (expected_results.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("unexpected result: kind %0d value %02h status %0d last %0d",
                         kind, value, status, last);
        end
        else
        begin
            want = expected_results.pop_front();
            if (kind !== want.kind || value !== want.value ||
                status !== want.status || last !== want.last)
            begin
                fails++;
                if (fails <= 10)
                    $display({"result %0d mismatch: expected kind %0d value %02h status %0d ",
                              "last %0d, got kind %0d value %02h status %0d last %0d"},
                             seen, want.kind, want.value, want.status, want.last,
                             kind, value, status, last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_phase = PH_IDLE;
            bytes_left = 8'd0;
            frame_sum  = 8'h00;
            expected_results.delete();
            fails = 0;
            seen  = 0;
            fail_total   <= 0;
            open_results <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_result(m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
            if (s_tvalid && s_tready)
                frame_link_item(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[16]);
            fail_total   <= fails;
            open_results <= expected_results.size();
            results_seen <= seen;
        end
    end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the display link framer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import dlf_pkg::*;

    localparam int LONG_HOLD = 200;

    typedef struct {
        cmd_t       cmd;
        logic [7:0] db;
        logic [7:0] flen;
        logic       rdy;
    } link_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] data_byte, [15:8] frame_length, [16] buffer_ready
    logic [1:0]  s_tuser = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [7:0] value, [8] status
    logic [1:0]  m_tuser;        // [1:0] kind
    logic        m_tlast;

    int fail_total;
    int open_results;
    int results_seen;
    int item_count = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;
    bit stall_request = 1'b0;

    always #6 clk = ~clk;

    display_link_framer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    link_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_total   (fail_total),
        .open_results (open_results),
        .results_seen (results_seen)
    );

    function automatic link_item_t make_item(input cmd_t cmd, input logic [7:0] db,
                                             input logic [7:0] flen, input logic rdy);
        link_item_t it;
        it.cmd  = cmd;
        it.db   = db;
        it.flen = flen;
        it.rdy  = rdy;
        return it;
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [7:0] db,
                             input logic [7:0] flen, input logic rdy);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, rdy, flen, db};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
    endtask

    // mostly complete write or read transactions, some cut short, some pure noise
    task automatic random_transaction();
        link_item_t seq[$];
        int         pick;
        int         flen;
        int         len;
        int         keep;
        bit         rdy;
        logic [7:0] ack;
        pick = $urandom_range(0, 99);
        flen = 0;
        if (pick < 42)
        begin
            case ($urandom_range(0, 9))
                0, 1:    flen = $urandom_range(7, 40);
                2:       flen = $urandom_range(0, 255);
                default: flen = $urandom_range(0, 6);
            endcase
            seq.push_back(make_item(CMD_WRITE_BEGIN, 8'($urandom), 8'(flen), 1'($urandom)));
            for (int i = 0; i < flen; i++)
                seq.push_back(make_item(CMD_WRITE_BYTE, 8'($urandom), 8'($urandom),
                                        1'($urandom)));
            ack = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ACK_BYTE;
            seq.push_back(make_item(CMD_RX_BYTE, ack, 8'($urandom), 1'($urandom)));
        end
        else if (pick < 84)
        begin
            rdy = ($urandom_range(0, 7) != 0);
            seq.push_back(make_item(CMD_READ_REQUEST, 8'($urandom), 8'($urandom), rdy));
            if (rdy)
            begin
                ack = ($urandom_range(0, 5) == 0) ? 8'($urandom) : ACK_BYTE;
                len = $urandom_range(0, 6);
                seq.push_back(make_item(CMD_RX_BYTE, ack, 8'($urandom), 1'($urandom)));
                seq.push_back(make_item(CMD_RX_BYTE, 8'($urandom), 8'($urandom),
                                        1'($urandom)));
                seq.push_back(make_item(CMD_RX_BYTE, 8'(len), 8'($urandom), 1'($urandom)));
                for (int i = 0; i < len; i++)
                    seq.push_back(make_item(CMD_RX_BYTE, 8'($urandom), 8'($urandom),
                                            1'($urandom)));
                seq.push_back(make_item(CMD_RX_BYTE, 8'($urandom), 8'($urandom),
                                        1'($urandom)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                seq.push_back(make_item(cmd_t'($urandom_range(0, 3)), 8'($urandom),
                                        8'($urandom), 1'($urandom)));
        end
        keep = seq.size();
        if (flen > 40)
            keep = $urandom_range(1, 8);
        else if (seq.size() > 1 && $urandom_range(0, 9) == 0)
            keep = $urandom_range(1, seq.size() - 1);
        for (int i = 0; i < keep; i++)
            send_item(seq[i].cmd, seq[i].db, seq[i].flen, seq[i].rdy);
    endtask

    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                m_tready <= 1'b0;
                stall_request = 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int drain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty write, then single-byte write answered with an error
        send_item(CMD_WRITE_BEGIN, 8'h00, 8'd0, 1'b0);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_WRITE_BEGIN, 8'hFF, 8'd1, 1'b1);
        send_item(CMD_WRITE_BYTE, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_RX_BYTE, 8'h15, 8'h00, 1'b0);
        // length 255 header wraps; abandoned by a new write
        send_item(CMD_WRITE_BEGIN, 8'h00, 8'd255, 1'b0);
        send_item(CMD_WRITE_BYTE, 8'hAA, 8'h00, 1'b0);
        send_item(CMD_WRITE_BEGIN, 8'h00, 8'd2, 1'b0);
        send_item(CMD_WRITE_BYTE, 8'h00, 8'h00, 1'b0);
        send_item(CMD_WRITE_BYTE, 8'h55, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        // buffer not ready, missing ack, zero length, one data byte
        send_item(CMD_READ_REQUEST, 8'h00, 8'h00, 1'b0);
        send_item(CMD_READ_REQUEST, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h07, 8'h00, 1'b1);
        send_item(CMD_READ_REQUEST, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'hFF, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h00, 8'h00, 1'b1);
        send_item(CMD_READ_REQUEST, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h01, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'hFF, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h5A, 8'h00, 1'b1);
        // out of sequence
        send_item(CMD_WRITE_BYTE, 8'h12, 8'h00, 1'b0);
        send_item(CMD_WRITE_BEGIN, 8'h00, 8'd3, 1'b0);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_WRITE_BYTE, 8'h34, 8'h00, 1'b0);

        while (item_count < 80)
            random_transaction();
        // receiver holds off while the sender keeps pushing
        src_idle_on = 1'b0;
        stall_request = 1'b1;
        while (item_count < 110)
            random_transaction();
        src_idle_on = 1'b1;
        while (item_count < 160)
            random_transaction();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        while (item_count < 200)
            random_transaction();
        s_tvalid <= 1'b0;

        @(posedge clk);
        drain = 0;
        while (open_results != 0 && drain < 4000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (12) @(posedge clk);

        $display("Ran %0d link items: writes (empty, wrapped, random payloads), reads", item_count);
        $display("with and without data, broken sequences and noise; %0d results checked",
                 results_seen);
        if (open_results != 0)
            $display("%0d expected results never arrived", open_results);
        if (fail_total == 0 && open_results == 0)
            $display("display_link_framer_top regression: pass");
        else
            $display("display_link_framer_top regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("display_link_framer_top regression: fail");
        $finish;
    end

endmodule
